### sv/rmv_pkg.sv
`timescale 1ns / 1ps

package rmv_pkg;

  // Port widths, fixed by the stream format
  localparam int IN_DATA_W  = 32;   // sample
  localparam int IN_USER_W  = 1;    // restart
  localparam int OUT_DATA_W = 128;  // mean, squared_dev_sum, samples_seen
  localparam int FIELD_W    = 32;   // mean and samples_seen field width
  localparam int DEV_W      = 64;   // squared_dev_sum field width

  // Commands from the stream wrapper to the core
  typedef struct packed {
    logic start;    // word accepted this cycle
    logic restart;  // that word opens a new series
    logic take;     // wrapper takes the finished result this cycle
  } rmv_ctl_t;

  // Core status back to the wrapper
  typedef struct packed {
    logic idle;     // can take a word
    logic done;     // result held and valid
  } rmv_stat_t;

endpackage

### sv/running_mean_variance_unit.sv
`timescale 1ns / 1ps

// Each word steps through DIFF, ABS, DIV, MEAN, DIFF2, MUL and ACC to DONE,
//   then moves to the output register; the first word of a series skips to DONE.
// A new word is taken only after the last one has left DONE; the bit-serial
//   divide and multiply share one adder.
// Reset: synchronous, active low; clears mean, deviation sum and count.
module running_mean_variance_unit #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rmv_pkg::IN_DATA_W-1:0]    in_tdata,   // [31:0] sample
  input  logic [rmv_pkg::IN_USER_W-1:0]    in_tuser,   // [0] restart
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rmv_pkg::OUT_DATA_W-1:0]   out_tdata   // [31:0] mean,
                                                       // [95:32] squared_dev_sum,
                                                       // [127:96] samples_seen
);

  import rmv_pkg::*;

  rmv_ctl_t                ctl;
  rmv_stat_t               stat;
  logic [SAMPLE_WIDTH-1:0] core_mean;
  logic [DEV_W-1:0]        core_dev;
  logic [COUNT_WIDTH-1:0]  core_cnt;

  // sign/zero extension to the 32-bit fields
  logic [SAMPLE_WIDTH+FIELD_W-1:0] mean_ext;
  logic [COUNT_WIDTH+FIELD_W-1:0]  cnt_ext;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Core takes a word only when idle; the output register lets it start
  // the next word while the previous result waits downstream.
  assign in_tready   = stat.idle;
  assign ctl.start   = in_tvalid & in_tready;
  assign ctl.restart = in_tuser[0];
  assign ctl.take    = stat.done & (~out_tvalid_r | out_tready);

  rmv_core #(
    .SW (SAMPLE_WIDTH),
    .CW (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sample  (in_tdata[SAMPLE_WIDTH-1:0]),
    .stat    (stat),
    .mean    (core_mean),
    .dev_sum (core_dev),
    .count   (core_cnt)
  );

  assign mean_ext = {{FIELD_W{core_mean[SAMPLE_WIDTH-1]}}, core_mean};
  assign cnt_ext  = {{FIELD_W{1'b0}}, core_cnt};

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (ctl.take) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {cnt_ext[FIELD_W-1:0], core_dev, mean_ext[FIELD_W-1:0]};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### sv/rmv_addsub.sv
`timescale 1ns / 1ps

// Shared adder/subtractor: sum = a + b, or a - b when sub is set.
// cout is the carry out; for a subtract it is high when a >= b (unsigned).
module rmv_addsub #(
  parameter int W = 34
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         cout
);

  logic [W:0] full;

  assign full = {1'b0, a} + {1'b0, b ^ {W{sub}}} + {{W{1'b0}}, sub};
  assign sum  = full[W-1:0];
  assign cout = full[W];

endmodule

### sv/rmv_core.sv
`timescale 1ns / 1ps

module rmv_core #(
  parameter int SW = 32,
  parameter int CW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmv_pkg::rmv_ctl_t     ctl,
  input  logic [SW-1:0]         sample,
  output rmv_pkg::rmv_stat_t    stat,
  output logic [SW-1:0]         mean,
  output logic [rmv_pkg::DEV_W-1:0] dev_sum,
  output logic [CW-1:0]         count
);

  import rmv_pkg::*;

  localparam int MW  = SW + 1;                        // |x - mean| width
  localparam int AW  = ((SW > CW) ? SW : CW) + 2;     // shared adder width
  localparam int PW  = 2 * MW;                        // product width
  localparam int ITW = $clog2(MW);
  localparam logic [ITW-1:0] IT_LAST = ITW'(MW - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_ABS   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MEAN  = 4'd4;
  localparam logic [3:0] S_DIFF2 = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [SW-1:0]    mean_r, mean_nxt;
  logic [DEV_W-1:0] dev_r, dev_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  logic [SW-1:0]    x_r, x_nxt;
  logic             neg_r, neg_nxt;
  logic [MW-1:0]    mag_r, mag_nxt;
  logic [MW-1:0]    quo_r, quo_nxt;
  logic [CW:0]      rem_r, rem_nxt;
  logic [MW-1:0]    mhi_r, mhi_nxt;
  logic [MW-1:0]    mlo_r, mlo_nxt;
  logic [ITW-1:0]   it_r, it_nxt;

  logic [AW-1:0]    op_a, op_b, add_sum;
  logic             op_sub, add_cout;

  logic [CW+1:0]    div_trial;
  logic [CW:0]      divisor;
  logic [MW:0]      mul_step;
  logic [PW+DEV_W-1:0] prod_ext;
  logic [DEV_W:0]   dev_add;
  logic [AW-1:0]    x_sx, mean_sx;

  rmv_addsub #(.W(AW)) u_addsub (
    .a    (op_a),
    .b    (op_b),
    .sub  (op_sub),
    .sum  (add_sum),
    .cout (add_cout)
  );

  assign x_sx      = AW'($signed(x_r));
  assign mean_sx   = AW'($signed(mean_r));
  assign divisor   = {1'b0, cnt_r} + (CW+1)'(1);
  assign div_trial = {rem_r, quo_r[MW-1]};
  assign mul_step  = mlo_r[0] ? add_sum[MW:0] : {1'b0, mhi_r};
  assign prod_ext  = {{DEV_W{1'b0}}, mhi_r, mlo_r};
  assign dev_add   = {1'b0, dev_r} + {1'b0, prod_ext[DEV_W-1:0]};

  // Operand selection for the shared adder
  always_comb begin
    op_a   = x_sx;
    op_b   = mean_sx;
    op_sub = 1'b1;
    case (state_r)
      S_DIFF: begin
        op_a = x_sx;
        op_b = mean_sx;
      end
      S_ABS, S_DIFF2: begin
        op_a = neg_r ? mean_sx : x_sx;
        op_b = neg_r ? x_sx : mean_sx;
      end
      S_DIV: begin
        op_a = AW'(div_trial);
        op_b = AW'(divisor);
      end
      S_MEAN: begin
        op_a   = mean_sx;
        op_b   = AW'(quo_r);
        op_sub = neg_r;
      end
      S_MUL: begin
        op_a   = AW'(mhi_r);
        op_b   = AW'(mag_r);
        op_sub = 1'b0;
      end
      default: begin
        op_a   = x_sx;
        op_b   = mean_sx;
        op_sub = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mean_nxt  = mean_r;
    dev_nxt   = dev_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    mhi_nxt   = mhi_r;
    mlo_nxt   = mlo_r;
    it_nxt    = it_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          x_nxt = sample;
          if (ctl.restart || cnt_r == '0) begin
            mean_nxt  = sample;
            dev_nxt   = '0;
            cnt_nxt   = CW'(1);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        neg_nxt   = add_sum[AW-1];
        state_nxt = S_ABS;
      end
      S_ABS: begin
        mag_nxt   = add_sum[MW-1:0];
        quo_nxt   = add_sum[MW-1:0];
        rem_nxt   = '0;
        it_nxt    = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring divide, one quotient bit a cycle
        rem_nxt = add_cout ? add_sum[CW:0] : div_trial[CW:0];
        quo_nxt = {quo_r[MW-2:0], add_cout};
        it_nxt  = it_r + ITW'(1);
        if (it_r == IT_LAST) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        mean_nxt  = add_sum[SW-1:0];
        state_nxt = S_DIFF2;
      end
      S_DIFF2: begin
        mlo_nxt   = add_sum[MW-1:0];
        mhi_nxt   = '0;
        it_nxt    = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // shift-add multiply, one multiplier bit a cycle
        mhi_nxt = mul_step[MW:1];
        mlo_nxt = {mul_step[0], mlo_r[MW-1:1]};
        it_nxt  = it_r + ITW'(1);
        if (it_r == IT_LAST) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        dev_nxt   = dev_add[DEV_W] ? {DEV_W{1'b1}} : dev_add[DEV_W-1:0];
        cnt_nxt   = (cnt_r == {CW{1'b1}}) ? cnt_r : cnt_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (ctl.take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mean_r  <= '0;
      dev_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mean_r  <= mean_nxt;
      dev_r   <= dev_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    mhi_r <= mhi_nxt;
    mlo_r <= mlo_nxt;
    it_r  <= it_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign mean      = mean_r;
  assign dev_sum   = dev_r;
  assign count     = cnt_r;

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> stat.idle)
    else $error("word started while core busy");

  a_done_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> cnt_r != '0)
    else $error("result with zero count");

  a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEAN) |-> (quo_r <= mag_r))
    else $error("mean step exceeds difference");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.done && !ctl.take) |=> (stat.done && $stable(mean_r) && $stable(dev_r)))
    else $error("result changed before taken");

endmodule
